/* rtl/core/scancode_set1_to_ascii_top_macros.svh */
// assertion macros shared by the scancode decoder files
`ifndef SCANCODE_SET1_TO_ASCII_TOP_MACROS_SVH
`define SCANCODE_SET1_TO_ASCII_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk, off during rst
`define SCS1_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs1 check failed");
// next-cycle implication, checked on clk, off during rst
`define SCS1_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs1 check failed");
`else
`define SCS1_ASSERT_IMP(lbl, ante, cons)
`define SCS1_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/scs1_pkg.sv */
package scs1_pkg;

  // special scancodes
  localparam logic [7:0] SHIFT_L_MAKE  = 8'h2A;
  localparam logic [7:0] SHIFT_R_MAKE  = 8'h36;
  localparam logic [7:0] SHIFT_L_BREAK = 8'hAA;
  localparam logic [7:0] SHIFT_R_BREAK = 8'hB6;
  localparam logic [7:0] PREFIX_EXT    = 8'hE0;
  localparam logic [7:0] TABLE_LIMIT   = 8'h60;

  // character classes that may be emitted
  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] PRINT_LOW     = 8'h20;
  localparam logic [7:0] PRINT_HIGH    = 8'h7E;

  localparam int CHAR_W = 7;

  // decode result handed from the decoder to the top level
  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] character;
  } scs1_res_t;

  // us-layout lookup for codes below the table limit
  function automatic logic [7:0] key_lookup(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h01: ch = 8'h1B; 7'h02: ch = 8'h31; 7'h03: ch = 8'h32; 7'h04: ch = 8'h33;
      7'h05: ch = 8'h34; 7'h06: ch = 8'h35; 7'h07: ch = 8'h36; 7'h08: ch = 8'h37;
      7'h09: ch = 8'h38; 7'h0A: ch = 8'h39; 7'h0B: ch = 8'h30; 7'h0C: ch = 8'h2D;
      7'h0D: ch = 8'h3D; 7'h0E: ch = 8'h08; 7'h0F: ch = 8'h09; 7'h10: ch = 8'h71;
      7'h11: ch = 8'h77; 7'h12: ch = 8'h65; 7'h13: ch = 8'h72; 7'h14: ch = 8'h74;
      7'h15: ch = 8'h79; 7'h16: ch = 8'h75; 7'h17: ch = 8'h69; 7'h18: ch = 8'h6F;
      7'h19: ch = 8'h70; 7'h1A: ch = 8'h5B; 7'h1B: ch = 8'h5D; 7'h1C: ch = 8'h0A;
      7'h1D: ch = 8'hF2; 7'h1E: ch = 8'h61; 7'h1F: ch = 8'h73; 7'h20: ch = 8'h64;
      7'h21: ch = 8'h66; 7'h22: ch = 8'h67; 7'h23: ch = 8'h68; 7'h24: ch = 8'h6A;
      7'h25: ch = 8'h6B; 7'h26: ch = 8'h6C; 7'h27: ch = 8'h3B; 7'h28: ch = 8'h27;
      7'h29: ch = 8'h60; 7'h2A: ch = 8'hF0; 7'h2B: ch = 8'h5C; 7'h2C: ch = 8'h7A;
      7'h2D: ch = 8'h78; 7'h2E: ch = 8'h63; 7'h2F: ch = 8'h76; 7'h30: ch = 8'h62;
      7'h31: ch = 8'h6E; 7'h32: ch = 8'h6D; 7'h33: ch = 8'h2C; 7'h34: ch = 8'h2E;
      7'h35: ch = 8'h2F; 7'h36: ch = 8'hF1; 7'h37: ch = 8'h2A; 7'h38: ch = 8'hF4;
      7'h39: ch = 8'h20; 7'h3A: ch = 8'hD0; 7'h3B: ch = 8'hC1; 7'h3C: ch = 8'hC2;
      7'h3D: ch = 8'hC3; 7'h3E: ch = 8'hC4; 7'h3F: ch = 8'hC5; 7'h40: ch = 8'hC6;
      7'h41: ch = 8'hC7; 7'h42: ch = 8'hC8; 7'h43: ch = 8'hC9; 7'h44: ch = 8'hCA;
      7'h45: ch = 8'hD1; 7'h46: ch = 8'hD2; 7'h47: ch = 8'h37; 7'h48: ch = 8'h38;
      7'h49: ch = 8'h39; 7'h4A: ch = 8'h2D; 7'h4B: ch = 8'h34; 7'h4C: ch = 8'h35;
      7'h4D: ch = 8'h36; 7'h4E: ch = 8'h2B; 7'h4F: ch = 8'h31; 7'h50: ch = 8'h32;
      7'h51: ch = 8'h33; 7'h52: ch = 8'h30; 7'h53: ch = 8'h2E; 7'h57: ch = 8'hCB;
      7'h58: ch = 8'hCC;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // us-layout shifted form of a character
  function automatic logic [CHAR_W-1:0] upper_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    if (ch >= 7'h61 && ch <= 7'h7A) begin
      up = ch - 7'h20;
    end else begin
      case (ch)
        7'h60: up = 7'h7E; 7'h31: up = 7'h21; 7'h32: up = 7'h40; 7'h33: up = 7'h23;
        7'h34: up = 7'h24; 7'h35: up = 7'h25; 7'h36: up = 7'h5E; 7'h37: up = 7'h26;
        7'h38: up = 7'h2A; 7'h39: up = 7'h28; 7'h30: up = 7'h29; 7'h2D: up = 7'h5F;
        7'h3D: up = 7'h2B; 7'h5B: up = 7'h7B; 7'h5D: up = 7'h7D; 7'h5C: up = 7'h7C;
        7'h3B: up = 7'h3A; 7'h27: up = 7'h22; 7'h2C: up = 7'h3C; 7'h2E: up = 7'h3E;
        7'h2F: up = 7'h3F;
        default: up = ch;
      endcase
    end
    return up;
  endfunction

endpackage

/* rtl/core/scs1_in_reg.sv */
module scs1_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_byte
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] scan_byte
);

  // room when empty or when the held item leaves this cycle
  assign s_axis_tready = !item_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // held scancode
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      scan_byte <= s_axis_tdata;
    end
  end

endmodule

/* rtl/core/scs1_decode.sv */
`include "scancode_set1_to_ascii_top_macros.svh"

module scs1_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          scan_byte,
  input  logic                typing_enable,
  output scs1_pkg::scs1_res_t res
);

  logic       shift_held;
  logic       shift_held_next;
  logic       prefix_pending;
  logic       prefix_pending_next;
  logic [7:0] looked_up;
  logic       printable;
  logic       is_shift_make;
  logic       is_shift_break;
  logic       is_prefix;

  // code classes
  assign is_shift_make  = scan_byte == scs1_pkg::SHIFT_L_MAKE ||
                          scan_byte == scs1_pkg::SHIFT_R_MAKE;
  assign is_shift_break = scan_byte == scs1_pkg::SHIFT_L_BREAK ||
                          scan_byte == scs1_pkg::SHIFT_R_BREAK;
  assign is_prefix      = scan_byte == scs1_pkg::PREFIX_EXT;

  // table lookup and emit check
  always_comb begin
    looked_up = (scan_byte < scs1_pkg::TABLE_LIMIT) ?
                scs1_pkg::key_lookup(scan_byte[6:0]) : 8'h00;
    printable = (looked_up >= scs1_pkg::PRINT_LOW && looked_up <= scs1_pkg::PRINT_HIGH) ||
                looked_up == scs1_pkg::CH_TAB || looked_up == scs1_pkg::CH_NEWLINE ||
                looked_up == scs1_pkg::CH_BACKSPACE;
    res.emit = typing_enable && printable && !prefix_pending &&
               !is_shift_make && !is_shift_break && !is_prefix;
    res.character = shift_held ? scs1_pkg::upper_of(looked_up[6:0]) : looked_up[6:0];
  end

  // flag updates
  always_comb begin
    shift_held_next     = shift_held;
    prefix_pending_next = prefix_pending;
    if (prefix_pending) begin
      prefix_pending_next = 1'b0;
    end else if (is_shift_make) begin
      shift_held_next = 1'b1;
    end else if (is_shift_break) begin
      shift_held_next = 1'b0;
    end else if (is_prefix) begin
      prefix_pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      prefix_pending <= 1'b0;
    end else if (step) begin
      shift_held     <= shift_held_next;
      prefix_pending <= prefix_pending_next;
    end
  end

  // byte after a prefix never produces a character
  `SCS1_ASSERT_IMP(a_prefix_swallow, step && prefix_pending, !res.emit)
  // shift make outside a prefix leaves shift held
  `SCS1_ASSERT_NEXT(a_shift_make, step && !prefix_pending && is_shift_make, shift_held)
  // prefix byte arms the swallow flag
  `SCS1_ASSERT_NEXT(a_prefix_arm, step && !prefix_pending && is_prefix, prefix_pending)

endmodule

/* rtl/core/scs1_out_reg.sv */
module scs1_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [scs1_pkg::CHAR_W-1:0] character,
  output logic                        free,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata    // [6:0] character, [7] zero
);

  logic [scs1_pkg::CHAR_W-1:0] held_char;

  // a slot opens when empty or when the held item is taken
  assign free         = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {1'b0, held_char};

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // held character
  always_ff @(posedge clk) begin
    if (load) begin
      held_char <= character;
    end
  end

endmodule

/* rtl/core/scancode_set1_to_ascii_top.sv */
// channel   | signals                        | content
// s_axis    | tvalid tready tdata[7:0]       | scan_byte in [7:0]
// m_axis    | tvalid tready tdata[7:0]       | character in [6:0], bit 7 zero
// cfg       | cfg_we cfg_wdata               | typing_enable
//
// one scancode is taken per cycle while no code waits on a full output slot; its
// character passes the input register and is then registered in the output register.
// rst is synchronous and clears both flags, typing_enable and all valid bits.
// a stalled m_axis only blocks codes that produce a character; others pass through.
`include "scancode_set1_to_ascii_top_macros.svh"

module scancode_set1_to_ascii_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] scan_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [6:0] character, [7] zero
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic                typing_enable;
  logic                item_valid;
  logic [7:0]          scan_byte;
  logic                out_free;
  logic                advance;
  logic                load;
  scs1_pkg::scs1_res_t res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      typing_enable <= 1'b0;
    end else if (cfg_we) begin
      typing_enable <= cfg_wdata;
    end
  end

  // item moves on unless its character finds the output slot full
  assign advance = item_valid && (!res.emit || out_free);
  assign load    = advance && res.emit;

  scs1_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (advance),
    .item_valid    (item_valid),
    .scan_byte     (scan_byte)
  );

  scs1_decode u_dec (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .scan_byte     (scan_byte),
    .typing_enable (typing_enable),
    .res           (res)
  );

  scs1_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .character     (res.character),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // nothing is emitted while typing is off
  `SCS1_ASSERT_IMP(a_load_enabled, load, typing_enable)
  // input only backs up behind a held item
  `SCS1_ASSERT_IMP(a_ready_low, !s_axis_tready, item_valid)
  // a loaded character is offered next cycle
  `SCS1_ASSERT_NEXT(a_load_shows, load, m_axis_tvalid)

endmodule

/* tb/tb_scancode_set1_to_ascii_top.sv */
`timescale 1ns / 1ps

module tb_scancode_set1_to_ascii_top;

  localparam logic [7:0] BREAK_BIT = 8'h80;
  localparam int         MAP_SIZE  = 96;

  // set 1 make code to us-layout character, codes 0x00..0x5f
  localparam logic [7:0] SET1_MAP [MAP_SIZE] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'hF2, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'hF0, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hF1, 8'h2A,
    8'hF4, 8'h20, 8'hD0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5,
    8'hC6, 8'hC7, 8'hC8, 8'hC9, 8'hCA, 8'hD1, 8'hD2, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'hCB,
    8'hCC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // directed row: typing setting, code, and an optional hand-written result
  typedef struct packed {
    logic       enable;
    logic [7:0] code;
    logic       typed;
    logic       emit;
    logic [6:0] ch;
  } key_row_t;

  localparam int ROW_COUNT = 29;
  localparam key_row_t KEY_ROWS [ROW_COUNT] = '{
    // typing off after reset: nothing comes out, shift still tracked
    '{1'b0, 8'h1E,                   1'b1, 1'b0, 7'h00},
    '{1'b0, scs1_pkg::SHIFT_L_MAKE,  1'b1, 1'b0, 7'h00},
    '{1'b0, scs1_pkg::SHIFT_L_BREAK, 1'b1, 1'b0, 7'h00},
    '{1'b0, 8'hFF,                   1'b1, 1'b0, 7'h00},
    // typing on: plain keys, control characters, table edges
    '{1'b1, 8'h1E,                   1'b1, 1'b1, 7'h61},
    '{1'b1, 8'h00,                   1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h01,                   1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h39,                   1'b1, 1'b1, 7'h20},
    '{1'b1, 8'h0E,                   1'b1, 1'b1, 7'h08},
    '{1'b1, 8'h0F,                   1'b1, 1'b1, 7'h09},
    '{1'b1, 8'h1C,                   1'b1, 1'b1, 7'h0A},
    '{1'b1, 8'h5F,                   1'b1, 1'b0, 7'h00},
    '{1'b1, scs1_pkg::TABLE_LIMIT,   1'b1, 1'b0, 7'h00},
    '{1'b1, 8'hFF,                   1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h9E,                   1'b1, 1'b0, 7'h00},
    // shifted keys, left then right shift
    '{1'b1, scs1_pkg::SHIFT_L_MAKE,  1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h1E,                   1'b0, 1'b0, 7'h00},
    '{1'b1, 8'h29,                   1'b0, 1'b0, 7'h00},
    '{1'b1, 8'h0F,                   1'b0, 1'b0, 7'h00},
    '{1'b1, scs1_pkg::SHIFT_L_BREAK, 1'b1, 1'b0, 7'h00},
    '{1'b1, scs1_pkg::SHIFT_R_MAKE,  1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h35,                   1'b0, 1'b0, 7'h00},
    // shift break swallowed after prefix, so shift stays down
    '{1'b1, scs1_pkg::PREFIX_EXT,    1'b1, 1'b0, 7'h00},
    '{1'b1, scs1_pkg::SHIFT_R_BREAK, 1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h02,                   1'b0, 1'b0, 7'h00},
    '{1'b1, scs1_pkg::SHIFT_R_BREAK, 1'b1, 1'b0, 7'h00},
    // double prefix: second one is swallowed, next key decodes
    '{1'b1, scs1_pkg::PREFIX_EXT,    1'b1, 1'b0, 7'h00},
    '{1'b1, scs1_pkg::PREFIX_EXT,    1'b1, 1'b0, 7'h00},
    '{1'b1, 8'h4E,                   1'b0, 1'b0, 7'h00}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;    // [7:0] scan_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [6:0] character, [7] zero
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  // hand-written result riding along with the current item
  logic       row_typed = 1'b0;
  logic       row_emit = 1'b0;
  logic [6:0] row_char = 7'h00;

  // predictor state
  bit         typing_on = 1'b0;
  bit         shift_down = 1'b0;
  bit         prefix_seen = 1'b0;

  logic [6:0] char_queue [$];
  int         mismatch_count = 0;
  int         key_items = 0;
  bit         idle_en = 1'b1;
  int         stall_left = 0;

  scancode_set1_to_ascii_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // us-layout shifted form
  function automatic logic [6:0] shifted_char(input logic [6:0] c);
    if (c >= 7'h61 && c <= 7'h7A) return c - 7'h20;
    case (c)
      7'h60: return 7'h7E;  // ` ~
      7'h31: return 7'h21;  // 1 !
      7'h32: return 7'h40;  // 2 @
      7'h33: return 7'h23;  // 3 #
      7'h34: return 7'h24;  // 4 $
      7'h35: return 7'h25;  // 5 %
      7'h36: return 7'h5E;  // 6 ^
      7'h37: return 7'h26;  // 7 &
      7'h38: return 7'h2A;  // 8 *
      7'h39: return 7'h28;  // 9 (
      7'h30: return 7'h29;  // 0 )
      7'h2D: return 7'h5F;  // - _
      7'h3D: return 7'h2B;  // = +
      7'h5B: return 7'h7B;  // [ {
      7'h5D: return 7'h7D;  // ] }
      7'h5C: return 7'h7C;  // \ |
      7'h3B: return 7'h3A;  // ; :
      7'h27: return 7'h22;  // ' "
      7'h2C: return 7'h3C;  // , <
      7'h2E: return 7'h3E;  // . >
      7'h2F: return 7'h3F;  // / ?
      default: return c;
    endcase
  endfunction

  // decode one scancode, updating shift and prefix flags
  task automatic decode_scancode(input logic [7:0] code, output bit fires,
                                 output logic [6:0] ch);
    logic [7:0] raw;
    fires = 1'b0;
    ch    = 7'h00;
    if (prefix_seen) begin
      prefix_seen = 1'b0;
    end else if (code == scs1_pkg::SHIFT_L_MAKE || code == scs1_pkg::SHIFT_R_MAKE) begin
      shift_down = 1'b1;
    end else if (code == scs1_pkg::SHIFT_L_BREAK || code == scs1_pkg::SHIFT_R_BREAK) begin
      shift_down = 1'b0;
    end else if (code == scs1_pkg::PREFIX_EXT) begin
      prefix_seen = 1'b1;
    end else begin
      raw   = (code < scs1_pkg::TABLE_LIMIT) ? SET1_MAP[code[6:0]] : 8'h00;
      fires = typing_on && ((raw >= scs1_pkg::PRINT_LOW && raw <= scs1_pkg::PRINT_HIGH) ||
              raw == scs1_pkg::CH_TAB || raw == scs1_pkg::CH_NEWLINE ||
              raw == scs1_pkg::CH_BACKSPACE);
      ch    = shift_down ? shifted_char(raw[6:0]) : raw[6:0];
    end
  endtask

  function automatic void flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endfunction

  // output stalls come in random bursts while idle_en is set
  always @(posedge clk) begin
    if (rst || !idle_en) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // check outputs first: an item taken at this edge cannot have its result yet
  always @(posedge clk) begin
    logic [6:0] want;
    bit         fires;
    logic [6:0] ch;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (char_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected character %02h", m_axis_tdata));
        end else begin
          want = char_queue.pop_front();
          if (m_axis_tdata !== {1'b0, want})
            flag_mismatch($sformatf("character: expected %02h, got %02h",
                                    {1'b0, want}, m_axis_tdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_scancode(s_axis_tdata, fires, ch);
        if (row_typed) begin
          fires = row_emit;
          ch    = row_char;
        end
        if (fires) char_queue.push_back(ch);
      end
    end
  end

  // present one scancode, with an occasional gap before it
  task automatic send_code(input logic [7:0] code, input bit typed = 1'b0,
                           input bit t_emit = 1'b0, input logic [6:0] t_char = 7'h00);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    row_typed     <= typed;
    row_emit      <= t_emit;
    row_char      <= t_char;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    key_items++;
  endtask

  // drain the pipe, then write typing_enable
  task automatic write_typing(input bit en);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (char_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    typing_on = en;
  endtask

  // mostly keystrokes and shifted words, some prefixes and raw noise
  task automatic random_traffic(input int target, input bit calm);
    int         stop;
    int         kind;
    logic [7:0] key;
    stop = key_items + target;
    if (calm) idle_en = 1'b0;
    while (key_items < stop) begin
      if (!calm && $urandom_range(0, 39) == 0) idle_en = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        key = 8'($urandom_range(0, scs1_pkg::TABLE_LIMIT - 1));
        send_code(key);
        if ($urandom_range(0, 1) == 1) send_code(key | BREAK_BIT);
      end else if (kind == 5) begin
        send_code($urandom_range(0, 1) ? scs1_pkg::SHIFT_L_MAKE : scs1_pkg::SHIFT_R_MAKE);
        repeat ($urandom_range(1, 4)) begin
          key = 8'($urandom_range(0, scs1_pkg::TABLE_LIMIT - 1));
          send_code(key);
        end
        send_code($urandom_range(0, 1) ? scs1_pkg::SHIFT_L_BREAK : scs1_pkg::SHIFT_R_BREAK);
      end else if (kind == 6) begin
        send_code(scs1_pkg::PREFIX_EXT);
        send_code(8'($urandom_range(0, 255)));
      end else begin
        send_code(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < ROW_COUNT; i++) begin
      if (KEY_ROWS[i].enable != typing_on) write_typing(KEY_ROWS[i].enable);
      send_code(KEY_ROWS[i].code, KEY_ROWS[i].typed, KEY_ROWS[i].emit, KEY_ROWS[i].ch);
    end

    // random phases across both typing settings, quiet at the end
    random_traffic(800, 1'b0);
    write_typing(1'b0);
    random_traffic(150, 1'b0);
    write_typing(1'b1);
    random_traffic(250, 1'b0);
    random_traffic(150, 1'b1);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (char_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("scancode_set1_to_ascii_top: match");
    end else begin
      $display("scancode_set1_to_ascii_top: mismatch");
    end
    $finish;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("scancode_set1_to_ascii_top: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/scs1_pkg.sv
rtl/core/scs1_in_reg.sv
rtl/core/scs1_decode.sv
rtl/core/scs1_out_reg.sv
rtl/core/scancode_set1_to_ascii_top.sv
tb/tb_scancode_set1_to_ascii_top.sv
